>>> rtl/tsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants of the TCP send window engine
// Request and result item layouts, codes and queue descriptor format.
// ----------------------------------------------------------------------------
package tsw_pkg;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_ACK  = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] KIND_NEW    = 2'd0;
	localparam logic [1:0] KIND_RETX   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic CFG_ISN     = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam int MAX_SEGS = 32;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] bytes_available;
		logic        stream_closed;
		logic        stream_error;
		logic        ack_valid;
		logic [31:0] ack_number;
		logic [15:0] adv_window;
		logic [31:0] elapsed_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] segment_seqno;
		logic [47:0] stream_offset;
		logic [9:0]  payload_len;
		logic        syn_flag;
		logic        fin_flag;
		logic        rst_flag;
		logic [16:0] seq_in_flight;
		logic [31:0] retx_count;
		logic        queue_full;
		logic        last;
	} rsp_t;

	// One outstanding segment as held in the queue memory.
	typedef struct packed {
		logic [47:0] abs;
		logic [10:0] plen;
		logic        syn;
		logic        fin;
		logic        rst;
	} desc_t;

	function automatic logic [11:0] seg_len(desc_t d);
		seg_len = {1'b0, d.plen} + {11'd0, d.syn} + {11'd0, d.fin};
	endfunction

endpackage

>>> rtl/tsw_queue_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_queue_mem: outstanding segment queue storage
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tsw_queue_mem #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tsw_pkg::desc_t  wdata,
	input  logic [AW-1:0]   raddr,
	output tsw_pkg::desc_t  rdata
);

	tsw_pkg::desc_t mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/tcp_send_window_retransmit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_send_window_retransmit: TCP sender window and retransmission engine
// Turns push, acknowledgment and tick events into segment descriptors.
// ----------------------------------------------------------------------------
// Usage:
// An event item enters on req/req_valid/req_stall. Each event yields zero or
// more segment items followed by one status item with last set, on
// rsp/rsp_valid/rsp_stall. Configuration is to be written through cfg_we,
// cfg_index and cfg_data only while no event is in progress; the block does
// not enforce this. One event is handled at a time; req_stall is high outside
// the idle state. A push emits up to 32 segments, each leaving from the push
// state once the output register is free. An acknowledgment reads each queue
// entry through the registered read port of the queue memory before checking
// and retiring it. A tick advances the timer and, on a timeout with entries
// queued, retransmits the oldest entry. An ignored acknowledgment or an
// unknown request goes straight to the status item.
// Reset clears all control state; the queue memory is not cleared, as only
// written entries are ever read. While the receiver stalls, the current
// result is held in the output register and no new item is loaded.
// ----------------------------------------------------------------------------
module tcp_send_window_retransmit #(
	parameter int MAX_PAYLOAD = 1000,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tsw_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tsw_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] QD = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] QLAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [10:0] MAXP = 11'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PUSH, ST_ACK_RD, ST_ACK_CHK, ST_TICK_RD, ST_TICK_CHK, ST_STATUS
	} state_t;

	state_t state_q;
	tsw_pkg::req_t req_q;

	logic [31:0] isn_q, init_to_q;
	logic syn_sent_q, fin_sent_q, err_q, peer_full_q;
	logic [47:0] next_abs_q, high_ack_q, ack_abs_q;
	logic [15:0] credit_q, max_win_q, tw_q, avail_q;
	logic [31:0] elapsed_q, timeout_q, retx_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [16:0] infl_q;
	logic [5:0] nseg_q;
	logic qfull_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	tsw_pkg::desc_t mem_wdata, mem_rdata;

	// Queue write address: tail of the ring.
	logic [CW:0] tail_sum;
	assign tail_sum = {1'b0, CW'(head_q)} + {1'b0, count_q};
	always_comb begin
		if (tail_sum >= {1'b0, QD}) mem_waddr = AW'(tail_sum - {1'b0, QD});
		else mem_waddr = AW'(tail_sum);
	end
	assign mem_raddr = head_q;

	tsw_queue_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	// Push segment formation from current state.
	logic want, cfin, syn_now;
	logic [15:0] room, plen16, avail_after, len16;
	logic [11:0] seg_l;
	tsw_pkg::desc_t pd;
	always_comb begin
		syn_now = !syn_sent_q;
		want = (tw_q != 16'd0 && avail_q != 16'd0)
			|| (tw_q != 16'd0 && req_q.stream_closed && !fin_sent_q) || !syn_sent_q;
		room = (tw_q > {15'd0, syn_now}) ? tw_q - {15'd0, syn_now} : 16'd0;
		plen16 = (room < avail_q) ? room : avail_q;
		if (plen16 > {5'd0, MAXP}) plen16 = {5'd0, MAXP};
		avail_after = avail_q - plen16;
		cfin = (tw_q > plen16 + {15'd0, syn_now}) && req_q.stream_closed
			&& !fin_sent_q && avail_after == 16'd0;
		pd.abs = next_abs_q;
		pd.plen = plen16[10:0];
		pd.syn = syn_now;
		pd.fin = cfin;
		pd.rst = req_q.stream_error || err_q;
		seg_l = tsw_pkg::seg_len(pd);
		len16 = {4'd0, seg_l};
	end

	assign mem_we = (state_q == ST_PUSH) && !(rsp_valid && rsp_stall) && want
		&& count_q < QD && nseg_q < 6'(tsw_pkg::MAX_SEGS) && seg_l != 12'd0;
	assign mem_wdata = pd;

	// Unwrap of the acknowledgment number around next_abs.
	logic [31:0] off;
	logic [48:0] cand;
	always_comb begin
		off = req.ack_number - isn_q - next_abs_q[31:0];
		cand = {1'b0, next_abs_q} + {17'd0, off};
		if (off > 32'h8000_0000 && cand >= 49'h1_0000_0000) cand = cand - 49'h1_0000_0000;
	end

	// The end of the head segment keeps its carry so it never wraps.
	logic [48:0] rd_end;
	logic [11:0] rd_len;
	logic [16:0] cadd;
	assign rd_len = tsw_pkg::seg_len(mem_rdata);
	assign rd_end = {1'b0, mem_rdata.abs} + {37'd0, rd_len};
	assign cadd = {1'b0, credit_q} + {5'd0, rd_len};

	logic [32:0] el_sum;
	logic [31:0] el_sat;
	assign el_sum = {1'b0, elapsed_q} + {1'b0, req_q.elapsed_ms};
	assign el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

	logic out_free;
	assign out_free = !(rsp_valid && rsp_stall);
	assign req_stall = (state_q != ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isn_q <= 32'd0;
			init_to_q <= 32'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsw_pkg::CFG_ISN: isn_q <= cfg_data;
				tsw_pkg::CFG_TIMEOUT: init_to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Event sequencer: holds state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [16:0] ws;
		logic [15:0] cr;
		logic [16:0] sum;
		logic [32:0] dbl;
		tsw_pkg::rsp_t nxt_rsp;
		logic emit;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			syn_sent_q <= 1'b0; fin_sent_q <= 1'b0; err_q <= 1'b0; peer_full_q <= 1'b0;
			next_abs_q <= '0; high_ack_q <= '0; credit_q <= 16'd1; max_win_q <= '0;
			elapsed_q <= '0; timeout_q <= 32'd1000; retx_q <= '0;
			head_q <= '0; count_q <= '0; infl_q <= '0;
			rsp_valid <= 1'b0; rsp <= '0; req_q <= '0; ack_abs_q <= '0;
			tw_q <= '0; avail_q <= '0; nseg_q <= '0; qfull_q <= 1'b0;
		end else begin
			emit = 1'b0;
			nxt_rsp = '0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						nseg_q <= '0;
						qfull_q <= 1'b0;
						avail_q <= fin_sent_q ? 16'd0 : req.bytes_available;
						tw_q <= (peer_full_q && credit_q != 16'd0) ? 16'd1 : credit_q;
						ack_abs_q <= cand[47:0];
						if (req.req_type == tsw_pkg::REQ_PUSH) state_q <= ST_PUSH;
						else if (req.req_type == tsw_pkg::REQ_ACK) begin
							if (!req.ack_valid) begin
								if (req.adv_window == 16'd0) err_q <= 1'b1;
								state_q <= ST_STATUS;
							end else if (cand[47:0] > next_abs_q || cand[48]) begin
								state_q <= ST_STATUS;
							end else state_q <= ST_ACK_RD;
						end else if (req.req_type == tsw_pkg::REQ_TICK) state_q <= ST_TICK_RD;
						else state_q <= ST_STATUS;
					end
				end
				ST_PUSH: begin
					// A full queue is reported before the segment cap ends the push.
					if (out_free) begin
						if (!want) begin
							state_q <= ST_STATUS;
						end else if (count_q >= QD) begin
							qfull_q <= 1'b1;
							state_q <= ST_STATUS;
						end else if (nseg_q >= 6'(tsw_pkg::MAX_SEGS) || seg_l == 12'd0) begin
							state_q <= ST_STATUS;
						end else begin
							emit = 1'b1;
							nxt_rsp.result_kind = tsw_pkg::KIND_NEW;
							nxt_rsp.segment_seqno = isn_q + next_abs_q[31:0];
							nxt_rsp.stream_offset = next_abs_q;
							nxt_rsp.payload_len = plen16[9:0];
							nxt_rsp.syn_flag = syn_now;
							nxt_rsp.fin_flag = cfin;
							nxt_rsp.rst_flag = pd.rst;
							if (syn_now) begin
								syn_sent_q <= 1'b1;
								timeout_q <= init_to_q;
							end
							if (cfin) fin_sent_q <= 1'b1;
							avail_q <= avail_after;
							credit_q <= (credit_q > len16) ? credit_q - len16 : 16'd0;
							tw_q <= (tw_q > len16) ? tw_q - len16 : 16'd0;
							count_q <= count_q + CW'(1);
							infl_q <= infl_q + {5'd0, seg_l};
							next_abs_q <= next_abs_q + {36'd0, seg_l};
							nseg_q <= nseg_q + 6'd1;
						end
					end
				end
				ST_ACK_RD: begin
					// Head entry read is issued; its data is checked in ST_ACK_CHK.
					if (count_q == '0) begin
						cr = credit_q;
						peer_full_q <= (req_q.adv_window == 16'd0);
						if (req_q.adv_window > max_win_q) begin
							sum = {1'b0, cr} + {1'b0, req_q.adv_window - max_win_q};
							credit_q <= sum[16] ? 16'hFFFF : sum[15:0];
							max_win_q <= req_q.adv_window;
						end
						if (high_ack_q < ack_abs_q) begin
							elapsed_q <= '0; high_ack_q <= ack_abs_q;
							retx_q <= '0; timeout_q <= init_to_q;
						end
						state_q <= ST_STATUS;
					end else state_q <= ST_ACK_CHK;
				end
				ST_ACK_CHK: begin
					if (rd_end > {1'b0, ack_abs_q}) begin
						cr = credit_q;
						peer_full_q <= (req_q.adv_window == 16'd0);
						if (req_q.adv_window > max_win_q) begin
							sum = {1'b0, cr} + {1'b0, req_q.adv_window - max_win_q};
							credit_q <= sum[16] ? 16'hFFFF : sum[15:0];
							max_win_q <= req_q.adv_window;
						end
						if (high_ack_q < ack_abs_q) begin
							elapsed_q <= '0; high_ack_q <= ack_abs_q;
							retx_q <= '0; timeout_q <= init_to_q;
						end
						state_q <= ST_STATUS;
					end else begin
						if (mem_rdata.syn) begin
							ws = (req_q.adv_window > 16'd1) ? {1'b0, req_q.adv_window} : 17'd1;
							credit_q <= ws[15:0];
							max_win_q <= ws[15:0];
						end else begin
							credit_q <= cadd[16] ? 16'hFFFF : cadd[15:0];
						end
						infl_q <= infl_q - {5'd0, rd_len};
						head_q <= (head_q == QLAST) ? '0 : head_q + AW'(1);
						count_q <= count_q - CW'(1);
						state_q <= ST_ACK_RD;
					end
				end
				ST_TICK_RD: begin
					// An empty queue clears the timer instead of advancing it.
					if (count_q == '0) begin
						elapsed_q <= '0;
						state_q <= ST_STATUS;
					end else begin
						elapsed_q <= el_sat;
						if (el_sat < timeout_q) state_q <= ST_STATUS;
						else state_q <= ST_TICK_CHK;
					end
				end
				ST_TICK_CHK: begin
					if (out_free) begin
						emit = 1'b1;
						nxt_rsp.result_kind = tsw_pkg::KIND_RETX;
						nxt_rsp.segment_seqno = isn_q + mem_rdata.abs[31:0];
						nxt_rsp.stream_offset = mem_rdata.abs;
						nxt_rsp.payload_len = mem_rdata.plen[9:0];
						nxt_rsp.syn_flag = mem_rdata.syn;
						nxt_rsp.fin_flag = mem_rdata.fin;
						nxt_rsp.rst_flag = mem_rdata.rst;
						if (retx_q != 32'hFFFF_FFFF) retx_q <= retx_q + 32'd1;
						if (!peer_full_q || mem_rdata.syn) begin
							dbl = {timeout_q, 1'b0};
							timeout_q <= dbl[32] ? 32'hFFFF_FFFF : dbl[31:0];
						end
						elapsed_q <= '0;
						state_q <= ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (out_free) begin
						emit = 1'b1;
						nxt_rsp.result_kind = tsw_pkg::KIND_STATUS;
						nxt_rsp.segment_seqno = isn_q + next_abs_q[31:0];
						nxt_rsp.stream_offset = next_abs_q;
						nxt_rsp.rst_flag = req_q.stream_error || err_q;
						nxt_rsp.seq_in_flight = infl_q;
						nxt_rsp.retx_count = retx_q;
						nxt_rsp.queue_full = qfull_q;
						nxt_rsp.last = 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Output register: load a new item or drop valid once accepted.
			if (emit) begin
				rsp_valid <= 1'b1;
				rsp <= nxt_rsp;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Checks on the queue bookkeeping and output sequencing.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QD) else $error("queue count exceeds depth");
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (infl_q == '0)) else $error("in-flight without entries");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < QD)) else $error("write to full queue");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> (rsp.result_kind == tsw_pkg::KIND_STATUS))
		else $error("last on non-status item");

endmodule

>>> tb/tcp_send_window_retransmit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_send_window_retransmit_test: self-checking bench of the TCP send engine
// Drives push, acknowledgment, tick and unknown events through random handshake gaps,
// predicts every segment and status item in the bench, and compares each
// result item field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tcp_send_window_retransmit_test;

	localparam int QDEPTH = 32;
	localparam int MAXPAY = 1000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// How the acknowledgment number of a pending item is chosen at drive time.
	typedef enum logic [1:0] {ACKNO_RAW, ACKNO_SENT, ACKNO_BEYOND} ackno_mode_t;

	typedef struct {
		tsw_pkg::req_t ev;
		ackno_mode_t   mode;
	} pending_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	tsw_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	tsw_pkg::rsp_t rsp;
	logic          cfg_we = 1'b0;
	logic          cfg_index = tsw_pkg::CFG_ISN;
	logic [31:0]   cfg_data = '0;

	pending_t      pending_events[$];
	tsw_pkg::rsp_t expected_results[$];
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            mismatches = 0;

	// Mirror of the engine's configuration and state.
	logic [31:0]     isn_cfg = '0;
	logic [31:0]     timeout_cfg = 32'd1000;
	bit              syn_sent, fin_sent, err_sticky, peer_full;
	logic [47:0]     next_seq, highest_ack;
	int unsigned     credit, max_win, in_flight;
	longint unsigned elapsed, cur_timeout, retx;
	tsw_pkg::desc_t  out_q[QDEPTH];
	int unsigned     q_head, q_count;

	tcp_send_window_retransmit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Appends to the pending and expected item queues.
	function void add_event(pending_t p);
		pending_events.insert(pending_events.size(), p);
	endfunction

	function void add_expect(tsw_pkg::rsp_t e);
		expected_results.insert(expected_results.size(), e);
	endfunction

	// Sequence space taken by one descriptor.
	function automatic int unsigned desc_span(tsw_pkg::desc_t d);
		return d.plen + d.syn + d.fin;
	endfunction

	function void expect_segment(logic [1:0] kind, tsw_pkg::desc_t d);
		tsw_pkg::rsp_t e;
		e = '0;
		e.result_kind = kind;
		e.segment_seqno = isn_cfg + d.abs[31:0];
		e.stream_offset = d.abs;
		e.payload_len = d.plen[9:0];
		e.syn_flag = d.syn;
		e.fin_flag = d.fin;
		e.rst_flag = d.rst;
		add_expect(e);
	endfunction

	// Segment generation for a push event; returns whether the queue filled up.
	function bit segment_push(tsw_pkg::req_t r);
		int unsigned    avail, tw, room, plen, span;
		int             n;
		bit             rst, want, qfull;
		tsw_pkg::desc_t d;
		avail = r.bytes_available;
		rst = r.stream_error | err_sticky;
		tw = credit;
		n = 0;
		qfull = 0;
		if (fin_sent)
			avail = 0;
		if (peer_full && tw > 0)
			tw = 1;
		while (1) begin
			want = (tw > 0 && avail > 0) || (tw > 0 && r.stream_closed && !fin_sent) ||
				!syn_sent;
			if (!want)
				break;
			if (q_count >= QDEPTH) begin
				qfull = 1;
				break;
			end
			if (n >= tsw_pkg::MAX_SEGS)
				break;
			d = '0;
			d.abs = next_seq;
			d.rst = rst;
			if (!syn_sent) begin
				syn_sent = 1;
				d.syn = 1;
				cur_timeout = timeout_cfg;
			end
			room = (tw > d.syn) ? tw - d.syn : 0;
			plen = (room < avail) ? room : avail;
			if (plen > MAXPAY)
				plen = MAXPAY;
			d.plen = 11'(plen);
			avail -= plen;
			if (tw > plen + d.syn && r.stream_closed && !fin_sent && avail == 0) begin
				d.fin = 1;
				fin_sent = 1;
			end
			span = desc_span(d);
			if (span == 0)
				break;
			expect_segment(tsw_pkg::KIND_NEW, d);
			n++;
			credit = (credit > span) ? credit - span : 0;
			tw = (tw > span) ? tw - span : 0;
			out_q[(q_head + q_count) % QDEPTH] = d;
			q_count++;
			in_flight += span;
			next_seq += 48'(span);
		end
		return qfull;
	endfunction

	// Retirement of acknowledged descriptors and window refresh.
	function void retire_acked(tsw_pkg::req_t r);
		int unsigned     win, span;
		logic [31:0]     off;
		longint unsigned ack;
		tsw_pkg::desc_t  d;
		win = r.adv_window;
		if (!r.ack_valid) begin
			if (win == 0)
				err_sticky = 1;
			return;
		end
		off = r.ack_number - isn_cfg - next_seq[31:0];
		ack = longint'(next_seq) + off;
		if (off > 32'h8000_0000 && ack >= 64'h1_0000_0000)
			ack -= 64'h1_0000_0000;
		if (ack > next_seq)
			return;
		while (q_count > 0) begin
			d = out_q[q_head];
			span = desc_span(d);
			if (longint'(d.abs) + span > ack)
				break;
			if (d.syn) begin
				credit = (win > 1) ? win : 1;
				max_win = credit;
			end else begin
				credit = (credit + span > 65535) ? 65535 : credit + span;
			end
			in_flight -= span;
			q_head = (q_head + 1) % QDEPTH;
			q_count--;
		end
		peer_full = (win == 0);
		if (win > max_win) begin
			credit = (credit + win - max_win > 65535) ? 65535 : credit + win - max_win;
			max_win = win;
		end
		if (highest_ack < ack) begin
			elapsed = 0;
			highest_ack = 48'(ack);
			retx = 0;
			cur_timeout = timeout_cfg;
		end
	endfunction

	// Timer advance and retransmission of the oldest descriptor.
	function void timer_tick(tsw_pkg::req_t r);
		tsw_pkg::desc_t d;
		elapsed += r.elapsed_ms;
		if (elapsed > 64'hFFFF_FFFF)
			elapsed = 64'hFFFF_FFFF;
		if (q_count == 0) begin
			elapsed = 0;
			return;
		end
		if (elapsed < cur_timeout)
			return;
		d = out_q[q_head];
		expect_segment(tsw_pkg::KIND_RETX, d);
		if (retx < 64'hFFFF_FFFF)
			retx++;
		if (!peer_full || d.syn) begin
			cur_timeout *= 2;
			if (cur_timeout > 64'hFFFF_FFFF)
				cur_timeout = 64'hFFFF_FFFF;
		end
		elapsed = 0;
	endfunction

	// Expected items of one accepted event, the status item last.
	function void predict_event(tsw_pkg::req_t r);
		tsw_pkg::rsp_t e;
		bit            qfull;
		qfull = 0;
		case (r.req_type)
			tsw_pkg::REQ_PUSH: qfull = segment_push(r);
			tsw_pkg::REQ_ACK:  retire_acked(r);
			tsw_pkg::REQ_TICK: timer_tick(r);
			default: ;
		endcase
		e = '0;
		e.result_kind = tsw_pkg::KIND_STATUS;
		e.segment_seqno = isn_cfg + next_seq[31:0];
		e.stream_offset = next_seq;
		e.rst_flag = r.stream_error | err_sticky;
		e.seq_in_flight = 17'(in_flight);
		e.retx_count = retx[31:0];
		e.queue_full = qfull;
		e.last = 1'b1;
		add_expect(e);
	endfunction

	// Fills in the acknowledgment number from the current sent state.
	function tsw_pkg::req_t resolve_ackno(pending_t p);
		tsw_pkg::req_t   r;
		int unsigned     k;
		longint unsigned ack;
		tsw_pkg::desc_t  d;
		r = p.ev;
		if (p.mode == ACKNO_SENT) begin
			k = $urandom_range(0, q_count);
			if (k == 0 || q_count == 0) begin
				ack = (q_count == 0) ? next_seq : out_q[q_head].abs;
			end else begin
				d = out_q[(q_head + k - 1) % QDEPTH];
				ack = d.abs + desc_span(d);
			end
			if (ack > highest_ack && $urandom_range(0, 7) == 0)
				ack--;
			r.ack_number = isn_cfg + ack[31:0];
		end else if (p.mode == ACKNO_BEYOND) begin
			r.ack_number = isn_cfg + next_seq[31:0] + $urandom_range(1, 5000);
		end
		return r;
	endfunction

	function pending_t make_event(logic [1:0] kind, logic [15:0] bytes, bit closed, bit err,
			ackno_mode_t mode, bit ackv, logic [31:0] ackno, logic [15:0] win,
			logic [31:0] ms);
		pending_t p;
		p.ev.req_type = kind;
		p.ev.bytes_available = bytes;
		p.ev.stream_closed = closed;
		p.ev.stream_error = err;
		p.ev.ack_valid = ackv;
		p.ev.ack_number = ackno;
		p.ev.adv_window = win;
		p.ev.elapsed_ms = ms;
		p.mode = mode;
		return p;
	endfunction

	function logic [15:0] pick_window();
		int unsigned c;
		c = $urandom_range(0, 99);
		if (c < 60)
			return 16'($urandom_range(1000, 65535));
		else if (c < 75)
			return 16'hFFFF;
		else if (c < 85)
			return 16'h0000;
		return 16'($urandom);
	endfunction

	// One random event, mostly well-formed traffic on the connection.
	function pending_t random_event();
		int unsigned c, b;
		logic [15:0] bytes;
		logic [31:0] ms;
		bit          err;
		c = $urandom_range(0, 99);
		err = ($urandom_range(0, 7) == 0);
		b = $urandom_range(0, 9);
		bytes = (b < 7) ? 16'($urandom_range(0, 2500)) : (b == 7) ? 16'd0 :
			(b == 8) ? 16'hFFFF : 16'($urandom);
		b = $urandom_range(0, 9);
		ms = (b < 4) ? 32'($urandom_range(0, 3000)) : (b < 7) ? $urandom :
			(b < 9) ? 32'hFFFF_FFFF : 32'd0;
		if (c < 40)
			return make_event(tsw_pkg::REQ_PUSH, bytes, 0, err, ACKNO_RAW, 1'($urandom),
				$urandom, 16'($urandom), $urandom);
		else if (c < 75)
			return make_event(tsw_pkg::REQ_ACK, 16'($urandom), 0, err, ACKNO_SENT, 1, 0,
				pick_window(), $urandom);
		else if (c < 80)
			return make_event(tsw_pkg::REQ_ACK, 16'($urandom), 0, err, ACKNO_RAW, 1,
				$urandom, pick_window(), $urandom);
		else if (c < 83)
			return make_event(tsw_pkg::REQ_ACK, 16'($urandom), 0, err, ACKNO_BEYOND, 1, 0,
				pick_window(), $urandom);
		else if (c < 85)
			return make_event(tsw_pkg::REQ_ACK, 16'($urandom), 0, err, ACKNO_RAW, 0,
				$urandom, 16'($urandom_range(1, 65535)), $urandom);
		else if (c < 98)
			return make_event(tsw_pkg::REQ_TICK, 16'($urandom), 0, err, ACKNO_RAW,
				1'($urandom), $urandom, 16'($urandom), ms);
		return make_event(REQ_UNKNOWN, 16'($urandom), 1'($urandom), err, ACKNO_RAW,
			1'($urandom), $urandom, 16'($urandom), $urandom);
	endfunction

	// Event driver: predicts each accepted item, then offers the next one.
	always @(posedge clk or negedge arst_n) begin : event_driver
		pending_t p;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				predict_event(req);
			if (!req_valid || !req_stall) begin
				if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					p = pending_events.pop_front();
					req <= resolve_ackno(p);
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function void check_field(string name, longint unsigned exp_v, longint unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// Result monitor: every accepted item against the oldest expectation.
	always @(posedge clk) begin : result_monitor
		tsw_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$error("result item with no expectation: %h", rsp);
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				check_field("result_kind", e.result_kind, rsp.result_kind);
				check_field("segment_seqno", e.segment_seqno, rsp.segment_seqno);
				check_field("stream_offset", e.stream_offset, rsp.stream_offset);
				check_field("payload_len", e.payload_len, rsp.payload_len);
				check_field("syn_flag", e.syn_flag, rsp.syn_flag);
				check_field("fin_flag", e.fin_flag, rsp.fin_flag);
				check_field("rst_flag", e.rst_flag, rsp.rst_flag);
				check_field("seq_in_flight", e.seq_in_flight, rsp.seq_in_flight);
				check_field("retx_count", e.retx_count, rsp.retx_count);
				check_field("queue_full", e.queue_full, rsp.queue_full);
				check_field("last", e.last, rsp.last);
			end
		end
	end

	task write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == tsw_pkg::CFG_ISN)
			isn_cfg = value;
		else
			timeout_cfg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every item is accepted and every result has arrived.
	task drain();
		do
			@(posedge clk);
		while (pending_events.size() > 0 || req_valid || expected_results.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task queue_random(int count);
		repeat (count) add_event(random_event());
	endtask

	initial begin
		syn_sent = 0; fin_sent = 0; err_sticky = 0; peer_full = 0;
		next_seq = '0; highest_ack = '0; credit = 1; max_win = 0;
		elapsed = 0; cur_timeout = 1000; retx = 0; q_head = 0; q_count = 0;
		in_flight = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: wrapping sequence numbers and a timeout of 1 ms.
		write_reg(tsw_pkg::CFG_ISN, 32'hFFFF_FF00);
		write_reg(tsw_pkg::CFG_TIMEOUT, 32'd1);
		send_idle_pct = 29;
		recv_idle_pct = 54;
		add_event(make_event(tsw_pkg::REQ_TICK, 0, 0, 0, ACKNO_RAW, 0, 0, 0, 5));
		add_event(make_event(tsw_pkg::REQ_PUSH, 0, 0, 0, ACKNO_RAW, 0, 0, 0, 0));
		add_event(make_event(tsw_pkg::REQ_PUSH, 100, 0, 0, ACKNO_RAW, 0, 0, 0, 0));
		add_event(make_event(tsw_pkg::REQ_TICK, 0, 0, 0, ACKNO_RAW, 0, 0, 0,
			32'hFFFF_FFFF));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_SENT, 1, 0, 16'hFFFF, 0));
		add_event(make_event(tsw_pkg::REQ_PUSH, 16'hFFFF, 0, 1, ACKNO_RAW, 0, 0, 0, 0));
		add_event(make_event(tsw_pkg::REQ_PUSH, 16'hFFFF, 0, 0, ACKNO_RAW, 0, 0, 0, 0));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_RAW, 0, 0, 500, 0));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_BEYOND, 1, 0, 800, 0));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_RAW, 1, 32'hFFFF_FFFF,
			900, 0));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_RAW, 1, 32'h0, 900, 0));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_SENT, 1, 0, 0, 0));
		add_event(make_event(tsw_pkg::REQ_PUSH, 500, 0, 0, ACKNO_RAW, 0, 0, 0, 0));
		add_event(make_event(tsw_pkg::REQ_TICK, 0, 0, 0, ACKNO_RAW, 0, 0, 0,
			32'hFFFF_FFFF));
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_SENT, 1, 0, 16'hFFFF, 0));
		add_event(make_event(REQ_UNKNOWN, 16'hFFFF, 1, 1, ACKNO_RAW, 1,
			32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
		add_event(make_event(tsw_pkg::REQ_TICK, 0, 0, 0, ACKNO_RAW, 0, 0, 0, 0));
		queue_random(130);
		drain();

		// Phase two: plain sequence numbers and the longest timeout.
		write_reg(tsw_pkg::CFG_ISN, 32'h0);
		write_reg(tsw_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
		send_idle_pct = 54;
		recv_idle_pct = 29;
		queue_random(150);
		drain();

		// Phase three: no idling; the stream closes, then the peer reports an error.
		write_reg(tsw_pkg::CFG_ISN, $urandom);
		write_reg(tsw_pkg::CFG_TIMEOUT, 32'd1000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(100);
		add_event(make_event(tsw_pkg::REQ_PUSH, 1200, 1, 0, ACKNO_RAW, 0, 0, 0, 0));
		queue_random(50);
		add_event(make_event(tsw_pkg::REQ_ACK, 0, 0, 0, ACKNO_RAW, 0, 0, 0, 0));
		queue_random(10);
		drain();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> tcp_send_window_retransmit.f
rtl/tsw_pkg.sv
rtl/tsw_queue_mem.sv
rtl/tcp_send_window_retransmit.sv
tb/tcp_send_window_retransmit_test.sv
